>>> rtl/core/dlsm_pkg.sv
// Shared types, widths and constants for the distance LOD select and morph block.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none
package dlsm_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int MAG_W   = COORD_WIDTH + 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int LIM_W   = 50;
  localparam int CMP_W   = (SQ_W > LIM_W) ? SQ_W : LIM_W;
  localparam int BR_W    = 20;
  localparam int LVL_W   = 4;
  localparam int START_W = BR_W + 15;
  localparam int END_W   = START_W + 1;
  localparam int DIV_W   = END_W + 1;
  localparam int LOD_W   = 3;
  localparam int MORPH_W = 17;
  localparam int IDX_W   = 3;

  // divide by five: base_range / 5 through a reciprocal
  localparam int BPROD_W = 2 * BR_W;
  localparam int M5A_SH  = 22;
  localparam logic [BR_W-1:0] M5A = 20'd838861;
  localparam int Q5_W    = BR_W - 2;
  // remainder part: (r << level) / 5 through a second reciprocal
  localparam int RL_W    = 18;
  localparam int RPROD_W = 2 * RL_W;
  localparam int M5B_SH  = 20;
  localparam logic [RL_W-1:0] M5B = 18'd209716;

  localparam int FQ_DEPTH = 8;
  localparam int FQ_AW    = 3;
  localparam int FQ_CW    = 4;
  localparam int INF_W    = 3;

  localparam logic [LOD_W-1:0]   LOD_FAR   = 3'd4;
  localparam logic [MORPH_W-1:0] MORPH_ONE = 17'd65536;

  localparam logic [LIM_W-1:0] LIM0_RST = 50'd163840000;
  localparam logic [LIM_W-1:0] LIM1_RST = 50'd655360000;
  localparam logic [LIM_W-1:0] LIM2_RST = 50'd2621440000;
  localparam logic [LIM_W-1:0] LIM3_RST = 50'd10485760000;
  localparam logic [BR_W-1:0]  BASE_RST = 20'd12800;

  typedef enum logic [IDX_W-1:0] {
    REG_LOD0 = 3'd0,
    REG_LOD1 = 3'd1,
    REG_LOD2 = 3'd2,
    REG_LOD3 = 3'd3,
    REG_BASE = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MM_ZERO = 2'd0,
    MM_ONE  = 2'd1,
    MM_DIV  = 2'd2
  } morph_mode_t;

  typedef struct packed {
    logic [LIM_W-1:0] lim0;
    logic [LIM_W-1:0] lim1;
    logic [LIM_W-1:0] lim2;
    logic [LIM_W-1:0] lim3;
    logic [BR_W-1:0]  base;
  } cfg_t;

  typedef struct packed {
    logic [SQ_W-1:0]    sq;
    logic [LOD_W-1:0]   lod;
    logic [END_W-1:0]   end_r;
    logic [START_W-1:0] width;
  } item_t;

  typedef struct packed {
    logic               valid;
    item_t              item;
  } push_t;

  typedef struct packed {
    logic [LOD_W-1:0]   lod;
    logic [END_W-1:0]   band_lo;
    logic [END_W-1:0]   end_r;
    logic [START_W-1:0] width;
    logic               wzero;
  } ctl_t;

endpackage
`default_nettype wire

>>> rtl/core/dlsm_front.sv
// Front end: squared distance, LOD classification and morph band bounds.
// Four register stages; depends on dlsm_pkg.
`default_nettype none
module dlsm_front (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  accept,
  input  wire logic signed [dlsm_pkg::COORD_WIDTH-1:0] camera_x,
  input  wire logic signed [dlsm_pkg::COORD_WIDTH-1:0] camera_y,
  input  wire logic signed [dlsm_pkg::COORD_WIDTH-1:0] camera_z,
  input  wire logic signed [dlsm_pkg::COORD_WIDTH-1:0] patch_x,
  input  wire logic signed [dlsm_pkg::COORD_WIDTH-1:0] patch_y,
  input  wire logic signed [dlsm_pkg::COORD_WIDTH-1:0] patch_z,
  input  wire logic [dlsm_pkg::LVL_W-1:0]            morph_level,
  input  wire dlsm_pkg::cfg_t                        cfg,
  output dlsm_pkg::push_t                            push,
  output logic [dlsm_pkg::INF_W-1:0]                 inflight
);

  localparam int MAG_W   = dlsm_pkg::MAG_W;
  localparam int SQ_W    = dlsm_pkg::SQ_W;
  localparam int CMP_W   = dlsm_pkg::CMP_W;
  localparam int BR_W    = dlsm_pkg::BR_W;
  localparam int LVL_W   = dlsm_pkg::LVL_W;
  localparam int START_W = dlsm_pkg::START_W;
  localparam int RL_W    = dlsm_pkg::RL_W;
  localparam int RPROD_W = dlsm_pkg::RPROD_W;
  localparam int BPROD_W = dlsm_pkg::BPROD_W;
  localparam int Q5_W    = dlsm_pkg::Q5_W;
  localparam int INF_W   = dlsm_pkg::INF_W;

  function automatic logic [MAG_W-1:0] abs_diff(
    input logic signed [dlsm_pkg::COORD_WIDTH-1:0] a,
    input logic signed [dlsm_pkg::COORD_WIDTH-1:0] b
  );
    logic signed [MAG_W-1:0] d;
    d = MAG_W'(a) - MAG_W'(b);
    abs_diff = d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
  endfunction

  logic                 s1_v;
  logic [MAG_W-1:0]     s1_mx, s1_my, s1_mz;
  logic [LVL_W-1:0]     s1_lvl;
  logic [BPROD_W-1:0]   s1_bprod;

  logic                 s2_v;
  logic [SQ_W-1:0]      s2_sx, s2_sy, s2_sz;
  logic [START_W-1:0]   s2_qsh, s2_start;
  logic [RL_W-1:0]      s2_rl;

  logic                 s3_v;
  logic [SQ_W-1:0]      s3_sum;
  logic [START_W-1:0]   s3_qsh, s3_start;
  logic [RPROD_W-1:0]   s3_rprod;

  logic                 s4_v;
  dlsm_pkg::item_t      s4_item;

  logic [Q5_W-1:0]      q5;
  logic [BR_W-1:0]      r5;
  logic [CMP_W-1:0]     sum_e;
  logic [dlsm_pkg::LOD_W-1:0] lod_sel;

  always_comb begin
    q5 = s1_bprod[BPROD_W-1 -: Q5_W];
    r5 = cfg.base - (BR_W'({q5, 2'b00}) + BR_W'(q5));
  end

  always_comb begin
    sum_e = CMP_W'(s3_sum);
    if (sum_e < CMP_W'(cfg.lim0)) begin
      lod_sel = 3'd0;
    end else if (sum_e < CMP_W'(cfg.lim1)) begin
      lod_sel = 3'd1;
    end else if (sum_e < CMP_W'(cfg.lim2)) begin
      lod_sel = 3'd2;
    end else if (sum_e < CMP_W'(cfg.lim3)) begin
      lod_sel = 3'd3;
    end else begin
      lod_sel = dlsm_pkg::LOD_FAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      s1_v <= accept;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_mx    <= abs_diff(camera_x, patch_x);
    s1_my    <= abs_diff(camera_y, patch_y);
    s1_mz    <= abs_diff(camera_z, patch_z);
    s1_lvl   <= morph_level;
    s1_bprod <= BPROD_W'(cfg.base) * BPROD_W'(dlsm_pkg::M5A);

    s2_sx    <= SQ_W'(s1_mx) * SQ_W'(s1_mx);
    s2_sy    <= SQ_W'(s1_my) * SQ_W'(s1_my);
    s2_sz    <= SQ_W'(s1_mz) * SQ_W'(s1_mz);
    s2_qsh   <= START_W'(START_W'(q5) << s1_lvl);
    s2_rl    <= RL_W'(RL_W'(r5[2:0]) << s1_lvl);
    s2_start <= START_W'(START_W'(cfg.base) << s1_lvl);

    s3_sum   <= s2_sx + s2_sy + s2_sz;
    s3_rprod <= RPROD_W'(s2_rl) * RPROD_W'(dlsm_pkg::M5B);
    s3_qsh   <= s2_qsh;
    s3_start <= s2_start;

    s4_item.sq    <= s3_sum;
    s4_item.lod   <= lod_sel;
    s4_item.end_r <= {s3_start, 1'b0};
    s4_item.width <= s3_qsh + START_W'(s3_rprod[RPROD_W-1:dlsm_pkg::M5B_SH]);
  end

  assign push.valid = s4_v;
  assign push.item  = s4_item;
  assign inflight   = INF_W'({2'b00, s1_v}) + INF_W'({2'b00, s2_v})
                    + INF_W'({2'b00, s3_v}) + INF_W'({2'b00, s4_v});

endmodule
`default_nettype wire

>>> rtl/core/dlsm_fifo.sv
// Short queue between the front end and the back end, registered read.
// Depends on dlsm_pkg.
`default_nettype none
module dlsm_fifo (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire dlsm_pkg::push_t              push,
  output logic                              rd_valid,
  output dlsm_pkg::item_t                   rd_item,
  output logic [dlsm_pkg::FQ_CW-1:0]        count
);

  localparam int FQ_AW = dlsm_pkg::FQ_AW;
  localparam int FQ_CW = dlsm_pkg::FQ_CW;

  dlsm_pkg::item_t     mem [dlsm_pkg::FQ_DEPTH];
  logic [FQ_AW-1:0]    wp, rp;
  logic                pop;

  assign pop = (count != '0);

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wp] <= push.item;
    end
    if (pop) begin
      rd_item <= mem[rp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      rp       <= '0;
      count    <= '0;
      rd_valid <= 1'b0;
    end else begin
      wp       <= wp + FQ_AW'(push.valid);
      rp       <= rp + FQ_AW'(pop);
      count    <= count + FQ_CW'(push.valid) - FQ_CW'(pop);
      rd_valid <= pop;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FQ_CW'(dlsm_pkg::FQ_DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> (count < FQ_CW'(dlsm_pkg::FQ_DEPTH) || pop))
    else $error("push into full queue");

  a_read_source: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> ($past(count) != '0))
    else $error("read from empty queue");

endmodule
`default_nettype wire

>>> rtl/core/dlsm_root.sv
// Back end, first part: pipelined integer square root, one root bit per stage.
// Depends on dlsm_pkg.
`default_nettype none
module dlsm_root (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire dlsm_pkg::item_t           in_item,
  output logic                           out_valid,
  output logic [dlsm_pkg::MAG_W-1:0]     out_root,
  output dlsm_pkg::ctl_t                 out_ctl
);

  localparam int RW    = dlsm_pkg::MAG_W;
  localparam int SQ_W  = dlsm_pkg::SQ_W;
  localparam int REM_W = RW + 3;
  localparam int END_W = dlsm_pkg::END_W;

  logic               v_q    [RW];
  logic [SQ_W-1:0]    x_q    [RW];
  logic [REM_W-1:0]   rem_q  [RW];
  logic [RW-1:0]      root_q [RW];
  dlsm_pkg::ctl_t     ctl_q  [RW];

  dlsm_pkg::ctl_t     ctl0;

  always_comb begin
    ctl0.lod     = in_item.lod;
    ctl0.band_lo = in_item.end_r - END_W'(in_item.width);
    ctl0.end_r   = in_item.end_r;
    ctl0.width   = in_item.width;
    ctl0.wzero   = (in_item.width == '0);
  end

  for (genvar i = 0; i < RW; i++) begin : g_st
    logic               v_in;
    logic [SQ_W-1:0]    x_in;
    logic [REM_W-1:0]   rem_in;
    logic [RW-1:0]      root_in;
    dlsm_pkg::ctl_t     ctl_in;
    logic [REM_W-1:0]   rem_sh, trial;
    logic               ge;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign x_in    = in_item.sq;
      assign rem_in  = '0;
      assign root_in = '0;
      assign ctl_in  = ctl0;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign x_in    = x_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign ctl_in  = ctl_q[i-1];
    end

    always_comb begin
      rem_sh = {rem_in[REM_W-3:0], x_in[SQ_W-1 -: 2]};
      trial  = REM_W'({root_in, 2'b01});
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      x_q[i]    <= {x_in[SQ_W-3:0], 2'b00};
      rem_q[i]  <= ge ? (rem_sh - trial) : rem_sh;
      root_q[i] <= {root_in[RW-2:0], ge};
      ctl_q[i]  <= ctl_in;
    end
  end

  assign out_valid = v_q[RW-1];
  assign out_root  = root_q[RW-1];
  assign out_ctl   = ctl_q[RW-1];

endmodule
`default_nettype wire

>>> rtl/core/dlsm_morph.sv
// Back end, second part: band classification and pipelined restoring divider
// for the morph factor, one quotient bit per stage. Depends on dlsm_pkg.
`default_nettype none
module dlsm_morph (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic [dlsm_pkg::MAG_W-1:0] in_root,
  input  wire dlsm_pkg::ctl_t             in_ctl,
  output logic                            done,
  output logic [dlsm_pkg::LOD_W-1:0]      lod_level,
  output logic [dlsm_pkg::MORPH_W-1:0]    morph_factor
);

  localparam int END_W   = dlsm_pkg::END_W;
  localparam int DIV_W   = dlsm_pkg::DIV_W;
  localparam int START_W = dlsm_pkg::START_W;
  localparam int LOD_W   = dlsm_pkg::LOD_W;
  localparam int QN      = dlsm_pkg::MORPH_W;

  logic                  c_v;
  dlsm_pkg::morph_mode_t c_mode, mode_sel;
  logic [END_W-1:0]      c_num, dist_e;
  logic [START_W-1:0]    c_w;
  logic [LOD_W-1:0]      c_lod;

  logic                  v_q    [QN];
  logic [DIV_W-1:0]      rem_q  [QN];
  logic [QN-1:0]         quo_q  [QN];
  logic [START_W-1:0]    w_q    [QN];
  dlsm_pkg::morph_mode_t mode_q [QN];
  logic [LOD_W-1:0]      lod_q  [QN];

  always_comb begin
    dist_e = END_W'(in_root);
    if (dist_e < in_ctl.band_lo) begin
      mode_sel = dlsm_pkg::MM_ZERO;
    end else if (dist_e > in_ctl.end_r || in_ctl.wzero) begin
      mode_sel = dlsm_pkg::MM_ONE;
    end else begin
      mode_sel = dlsm_pkg::MM_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else begin
      c_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    c_mode <= mode_sel;
    c_num  <= dist_e - in_ctl.band_lo;
    c_w    <= in_ctl.width;
    c_lod  <= in_ctl.lod;
  end

  for (genvar i = 0; i < QN; i++) begin : g_div
    logic                  v_in;
    logic [DIV_W-1:0]      rem_in, w_e, diff;
    logic [QN-1:0]         quo_in;
    logic [START_W-1:0]    w_in;
    dlsm_pkg::morph_mode_t mode_in;
    logic [LOD_W-1:0]      lod_in;
    logic                  ge;

    if (i == 0) begin : g_first
      assign v_in    = c_v;
      assign rem_in  = DIV_W'(c_num);
      assign quo_in  = '0;
      assign w_in    = c_w;
      assign mode_in = c_mode;
      assign lod_in  = c_lod;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign quo_in  = quo_q[i-1];
      assign w_in    = w_q[i-1];
      assign mode_in = mode_q[i-1];
      assign lod_in  = lod_q[i-1];
    end

    always_comb begin
      w_e  = DIV_W'(w_in);
      ge   = (rem_in >= w_e);
      diff = ge ? (rem_in - w_e) : rem_in;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[i]  <= {diff[DIV_W-2:0], 1'b0};
      quo_q[i]  <= {quo_in[QN-2:0], ge};
      w_q[i]    <= w_in;
      mode_q[i] <= mode_in;
      lod_q[i]  <= lod_in;
    end
  end

  always_comb begin
    case (mode_q[QN-1])
      dlsm_pkg::MM_ZERO: morph_factor = '0;
      dlsm_pkg::MM_ONE:  morph_factor = dlsm_pkg::MORPH_ONE;
      dlsm_pkg::MM_DIV:  morph_factor = quo_q[QN-1];
      default:           morph_factor = '0;
    endcase
  end

  assign done      = v_q[QN-1];
  assign lod_level = lod_q[QN-1];

endmodule
`default_nettype wire

>>> rtl/core/distance_lod_select_and_morph.sv
// Top level: distance LOD select and morph factor; register file, front end,
// queue and back end. Depends on dlsm_pkg and the dlsm_* modules.
// Path: 4 front stages, 2 queue registers, 25 square root stages, 1 classify stage and
// 17 divider stages. Throughput: one item per cycle while busy is low.
// The receiver cannot stall; busy rises only if the queue would fill.
// Synchronous reset clears the pipeline and loads the register reset values.
`default_nettype none
module distance_lod_select_and_morph (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    start,
  output logic                                         busy,
  input  wire logic signed [dlsm_pkg::COORD_WIDTH-1:0] camera_x,
  input  wire logic signed [dlsm_pkg::COORD_WIDTH-1:0] camera_y,
  input  wire logic signed [dlsm_pkg::COORD_WIDTH-1:0] camera_z,
  input  wire logic signed [dlsm_pkg::COORD_WIDTH-1:0] patch_x,
  input  wire logic signed [dlsm_pkg::COORD_WIDTH-1:0] patch_y,
  input  wire logic signed [dlsm_pkg::COORD_WIDTH-1:0] patch_z,
  input  wire logic [dlsm_pkg::LVL_W-1:0]              morph_level,
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [dlsm_pkg::IDX_W-1:0]              cfg_index,
  input  wire logic [dlsm_pkg::LIM_W-1:0]              cfg_data,
  output logic                                         done,
  output logic [dlsm_pkg::LOD_W-1:0]                   lod_level,
  output logic [dlsm_pkg::MORPH_W-1:0]                 morph_factor
);

  localparam int OCC_W = dlsm_pkg::FQ_CW + 1;

  dlsm_pkg::cfg_t                cfg;
  dlsm_pkg::push_t               push;
  logic [dlsm_pkg::INF_W-1:0]    inflight;
  logic [dlsm_pkg::FQ_CW-1:0]    fq_count;
  logic                          fq_valid;
  dlsm_pkg::item_t               fq_item;
  logic                          rt_valid;
  logic [dlsm_pkg::MAG_W-1:0]    rt_root;
  dlsm_pkg::ctl_t                rt_ctl;
  logic                          accept;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = (OCC_W'(fq_count) + OCC_W'(inflight)) >= OCC_W'(dlsm_pkg::FQ_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lim0 <= dlsm_pkg::LIM0_RST;
      cfg.lim1 <= dlsm_pkg::LIM1_RST;
      cfg.lim2 <= dlsm_pkg::LIM2_RST;
      cfg.lim3 <= dlsm_pkg::LIM3_RST;
      cfg.base <= dlsm_pkg::BASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (dlsm_pkg::cfg_reg_t'(cfg_index))
        dlsm_pkg::REG_LOD0: cfg.lim0 <= cfg_data;
        dlsm_pkg::REG_LOD1: cfg.lim1 <= cfg_data;
        dlsm_pkg::REG_LOD2: cfg.lim2 <= cfg_data;
        dlsm_pkg::REG_LOD3: cfg.lim3 <= cfg_data;
        dlsm_pkg::REG_BASE: cfg.base <= cfg_data[dlsm_pkg::BR_W-1:0];
        default: ;
      endcase
    end
  end

  dlsm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .camera_x    (camera_x),
    .camera_y    (camera_y),
    .camera_z    (camera_z),
    .patch_x     (patch_x),
    .patch_y     (patch_y),
    .patch_z     (patch_z),
    .morph_level (morph_level),
    .cfg         (cfg),
    .push        (push),
    .inflight    (inflight)
  );

  dlsm_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .rd_valid (fq_valid),
    .rd_item  (fq_item),
    .count    (fq_count)
  );

  dlsm_root u_root (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_item   (fq_item),
    .out_valid (rt_valid),
    .out_root  (rt_root),
    .out_ctl   (rt_ctl)
  );

  dlsm_morph u_morph (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (rt_valid),
    .in_root      (rt_root),
    .in_ctl       (rt_ctl),
    .done         (done),
    .lod_level    (lod_level),
    .morph_factor (morph_factor)
  );

endmodule
`default_nettype wire
